// ===== design/tcw_pkg.sv =====
// shared constants, codes and types of the text console writer
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_GOTO  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

  // register select is paddr bit 2
  localparam logic REG_ATTR = 1'b0;

  typedef struct packed {
    logic go;
    logic adv;
    logic nl;
    logic home;
  } cur_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [IDX_W-1:0]  cursor_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
  } out_word_t;

endpackage

// ===== design/tcw_intf.sv =====
// valid/ready channel interfaces for command words and result words
interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;

  modport source (output valid, operation, char_code, column, row, input ready);
  modport sink   (input valid, operation, char_code, column, row, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [IDX_W-1:0]  cursor_index;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attribute;

  modport source (output valid, cursor_column, cursor_row, cursor_index, cell_char,
                  cell_attribute, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_index, cell_char,
                  cell_attribute, output ready);
endinterface

// ===== design/tcw_cursor.sv =====
// cursor registers with advance, wrap, goto and home
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcw_pkg::cur_cmd_t                 cmd,
  input  logic [$clog2(COLUMNS)-1:0]        go_col,
  input  logic [$clog2(ROWS)-1:0]           go_row,
  output logic [$clog2(COLUMNS)-1:0]        col_o,
  output logic [$clog2(ROWS)-1:0]           row_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]   idx_o,
  output logic [$clog2(COLUMNS)-1:0]        nxt_col,
  output logic [$clog2(ROWS)-1:0]           nxt_row,
  output logic [$clog2(COLUMNS*ROWS)-1:0]   nxt_idx
);
  import tcw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = $clog2(COLUMNS * ROWS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          wrap;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    wrap    = cmd.nl || (cmd.adv && (col_r == LAST_COL));
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = LAST_ROW;
    end else if (cmd.go) begin
      col_nxt = go_col;
      row_nxt = go_row;
    end else if (wrap) begin
      col_nxt = '0;
      if (row_r != LAST_ROW) begin
        row_nxt = row_r + 1'b1;
      end
    end else if (cmd.adv) begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= LAST_ROW;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col_o   = col_r;
  assign row_o   = row_r;
  assign nxt_col = col_nxt;
  assign nxt_row = row_nxt;
  assign idx_o   = AW'(row_r * COLUMNS + col_r);
  assign nxt_idx = AW'(row_nxt * COLUMNS + col_nxt);

endmodule

// ===== design/text_console_writer_top.sv =====
// text console writer: character store, cursor, sequencer and apb register
//
// in_ch carries command words (put character, clear, goto, read cell), out_ch
// returns one result word per command: the cursor after the command, its
// linear index, and for read cell the stored character and attribute.
// psel/penable/pwrite/paddr/pwdata set the attribute byte (byte address 0),
// prdata reads it back; pready is always high.
// a put that does not scroll and a goto load the result register when they are
// taken; a read cell waits in S_FIN for the registered read port of the store.
// a put that wraps on the bottom row scrolls the store through its single
// read and write port, one cell a cycle.
// clear sweeps the write port over every cell.
// after reset a clearing pass over all cells (2000 by default) fills
// the store with spaces in attribute 15; in_ch.ready stays low meanwhile.
// a finished result sits in an output register; a new command is taken while
// it is being drained, and while the receiver stalls the word is held and
// further commands wait.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcw_pkg::CFG_AW-1:0] paddr,
  input  logic [tcw_pkg::CFG_DW-1:0] pwdata,
  output logic [tcw_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import tcw_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] BLANK_FROM = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCRL = 3'd2;
  localparam logic [2:0] S_DRN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic              cp_valid_r, cp_blank_r;
  logic [AW-1:0]     cp_addr_r;
  logic [CELL_W-1:0] rd_q;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r;

  logic [CELL_W-1:0] mem [CELLS];

  logic              we, re;
  logic [AW-1:0]     wa, ra;
  logic [CELL_W-1:0] wd;
  logic              out_free, accept, load_out, is_nl, scroll_put, cfg_wr;
  logic [CW-1:0]     tgt_col, cur_col, nxt_col;
  logic [RW-1:0]     tgt_row, cur_row, nxt_row;
  logic [AW-1:0]     tgt_idx, cur_idx, nxt_idx;
  cur_cmd_t          cmd;

  // target cell with saturation
  assign tgt_col = (32'(in_ch.column) >= COLUMNS) ? LAST_COL : CW'(in_ch.column);
  assign tgt_row = (32'(in_ch.row) >= ROWS) ? LAST_ROW : RW'(in_ch.row);
  assign tgt_idx = AW'(tgt_row * COLUMNS + tgt_col);

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_nl       = (in_ch.char_code == NEWLINE_CHAR);
  assign scroll_put  = (is_nl || (cur_col == LAST_COL)) && (cur_row == LAST_ROW);

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .go_col  (tgt_col),
    .go_row  (tgt_row),
    .col_o   (cur_col),
    .row_o   (cur_row),
    .idx_o   (cur_idx),
    .nxt_col (nxt_col),
    .nxt_row (nxt_row),
    .nxt_idx (nxt_idx)
  );

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;
    op_nxt    = op_r;
    cmd       = '0;
    we        = 1'b0;
    wa        = cur_idx;
    wd        = {attr_r, in_ch.char_code};
    re        = 1'b0;
    ra        = tgt_idx;
    load_out  = 1'b0;
    case (state_r)
      S_FILL: begin
        we      = 1'b1;
        wa      = ptr_r;
        wd      = fill_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_ch.operation;
          case (in_ch.operation)
            OP_PUT: begin
              if (is_nl) begin
                cmd.nl = 1'b1;
              end else begin
                cmd.adv = 1'b1;
                we      = 1'b1;
              end
              if (scroll_put) begin
                ptr_nxt   = '0;
                state_nxt = S_SCRL;
              end else begin
                load_out = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd.home  = 1'b1;
              fill_nxt  = {attr_r, BLANK_CHAR};
              ptr_nxt   = '0;
              pend_nxt  = 1'b1;
              state_nxt = S_FILL;
            end
            OP_GOTO: begin
              cmd.go   = 1'b1;
              load_out = 1'b1;
            end
            default: begin
              re        = 1'b1;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCRL: begin
        re      = (ptr_r < BLANK_FROM);
        ra      = ptr_r + ROW_STEP;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = S_DRN;
        end
      end
      S_DRN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // delayed write of the scroll copy
    if (cp_valid_r) begin
      we = 1'b1;
      wa = cp_addr_r;
      wd = cp_blank_r ? {attr_r, BLANK_CHAR} : rd_q;
    end
  end

  always_comb begin
    out_nxt.cursor_column = COL_W'(nxt_col);
    out_nxt.cursor_row    = ROW_W'(nxt_row);
    out_nxt.cursor_index  = IDX_W'(nxt_idx);
    if ((state_r == S_FIN) && (op_r == OP_READ)) begin
      out_nxt.cell_char      = rd_q[CHAR_W-1:0];
      out_nxt.cell_attribute = rd_q[CELL_W-1:CHAR_W];
    end else begin
      out_nxt.cell_char      = '0;
      out_nxt.cell_attribute = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      fill_r      <= {RESET_ATTR, BLANK_CHAR};
      cp_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      pend_r     <= pend_nxt;
      fill_r     <= fill_nxt;
      cp_valid_r <= (state_r == S_SCRL);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cp_addr_r  <= ptr_r;
    cp_blank_r <= (ptr_r >= BLANK_FROM);
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_column  = out_r.cursor_column;
  assign out_ch.cursor_row     = out_r.cursor_row;
  assign out_ch.cursor_index   = out_r.cursor_index;
  assign out_ch.cell_char      = out_r.cell_char;
  assign out_ch.cell_attribute = out_r.cell_attribute;

  // attribute register
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ATTR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_wr) begin
      attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ATTR) ? CFG_DW'(attr_r) : '0;

endmodule

// ===== design/tcw_checker.sv =====
// port-level checks of the text console writer and their bind
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tcw_pkg::COL_W-1:0]  cursor_column,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  input logic [tcw_pkg::IDX_W-1:0]  cursor_index,
  input logic [tcw_pkg::CHAR_W-1:0] cell_char,
  input logic [tcw_pkg::ATTR_W-1:0] cell_attribute
);
  import tcw_pkg::*;

  // a word is taken only when the result register has room
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("word accepted while result register full");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_column) &&
      $stable(cursor_row) && $stable(cursor_index) && $stable(cell_char) &&
      $stable(cell_attribute)))
    else $error("stalled result word changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS)))
    else $error("cursor out of range");

  a_cursor_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((COLUMNS > 128) || (COLUMNS * ROWS > 2048) ||
      (cursor_index == IDX_W'(cursor_row * COLUMNS + cursor_column))))
    else $error("cursor index does not match row and column");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cursor_column  (out_ch.cursor_column),
  .cursor_row     (out_ch.cursor_row),
  .cursor_index   (out_ch.cursor_index),
  .cell_char      (out_ch.cell_char),
  .cell_attribute (out_ch.cell_attribute)
);
